// ===== hw/rtl/dgf_pkg.sv =====
package dgf_pkg;

    // Fixed-point constants
    localparam logic [31:0] ONE_Q30     = 32'd1073741824;
    localparam logic [47:0] SQRT3_Q30   = 48'd1859775393;
    localparam logic [47:0] DEFAULT_DT  = 48'd10000;
    localparam logic [31:0] TCONST_INIT = 32'd1000000;

    localparam int unsigned PROD_W = 81;
    localparam int unsigned ACC_W  = 66;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_GAIN_LONG   = 3'd0,
        REG_GAIN_LAT    = 3'd1,
        REG_GAIN_VERT   = 3'd2,
        REG_TCONST_LONG = 3'd3,
        REG_TCONST_LAT  = 3'd4,
        REG_TCONST_VERT = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][30:0] gain;
        logic [2:0][31:0] tconst;
    } cfg_t;

    typedef struct packed {
        logic [47:0]        time_us;
        logic signed [15:0] noise_long;
        logic signed [15:0] noise_lat;
        logic signed [15:0] noise_vert;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] gust_long;
        logic signed [31:0] gust_lat;
        logic signed [31:0] gust_vert;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DSTART,
        ST_DIV,
        ST_LOAD,
        ST_MUL,
        ST_POST,
        ST_FIN,
        ST_OUT
    } state_t;

    // Multiply program; first order runs OP_KP..OP_CY1, second order OP_QQ..OP_A2Y
    typedef enum logic [3:0] {
        OP_KP,
        OP_GX,
        OP_CY1,
        OP_QQ,
        OP_PQ,
        OP_S,
        OP_CC,
        OP_G0,
        OP_G1,
        OP_G0X,
        OP_G1X,
        OP_C2Y,
        OP_A2Y
    } op_t;

    // Round half up, then arithmetic shift right by n
    function automatic logic signed [PROD_W-1:0] rnd_shr(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              n
    );
        logic signed [PROD_W-1:0] w;
        w = v + signed'(PROD_W'(1) << (n - 1));
        return w >>> n;
    endfunction

    // Round by 2^26 and clamp to 32 bits
    function automatic logic signed [31:0] sat_rnd26(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] w;
        logic signed [ACC_W-1:0] sh;
        w  = a + signed'(ACC_W'(1) << 25);
        sh = w >>> 26;
        if (sh > signed'(ACC_W'(32'h7FFFFFFF)))
            return 32'sh7FFFFFFF;
        else if (sh < -signed'(ACC_W'(33'h080000000)))
            return 32'sh80000000;
        else
            return sh[31:0];
    endfunction

endpackage

// ===== hw/rtl/dryden_gust_filter_bank.sv =====
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------
// in       | in_valid / in_ready   | in_data: time stamp, 3 noise samples
// out      | out_valid / out_ready | out_data: 3 saturated gust velocities
// config   | psel/penable/pwrite   | paddr, pwdata, prdata; pready tied high
//
// From acceptance to a loaded result, a transaction runs per axis one 32-step
// ratio division, then 3 (longitudinal) or 10 (lateral, vertical) 33-step
// multiplies on the one shared serial multiplier.
// in_ready is high only in idle; a finished result may still wait in the
// output register while the next transaction is taken in.
// rst_n clears the filter histories, the previous time stamp and the registers.
module dryden_gust_filter_bank (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dgf_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dgf_pkg::out_item_t   out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import dgf_pkg::*;

    cfg_t   cfg;
    state_t state_reg, state_next;
    op_t    op_reg;
    logic [1:0] axis_reg;

    logic [47:0]              prev_time_reg;
    logic [47:0]              dt_reg;
    logic signed [15:0]       x_reg     [3];
    logic signed [15:0]       xprev_reg [3];
    logic signed [31:0]       y1_reg    [3];
    logic signed [31:0]       y2_reg    [3];
    logic [30:0]              p_reg;
    logic signed [47:0]       g0_reg, g1_reg;
    logic signed [31:0]       q2_reg, pq_reg, s_reg, a2_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    out_item_t                out_reg;
    logic                     out_valid_reg;

    logic                     div_done;
    logic [30:0]              div_ratio;
    logic                     mul_done;
    logic signed [PROD_W-1:0] prod;
    logic signed [47:0]       op_a;
    logic signed [32:0]       op_b;

    logic [31:0]              c_val;
    logic [32:0]              c2_val;
    logic [30:0]              q_val;
    logic signed [32:0]       qs_sum, qs_dif;
    logic signed [16:0]       xx_sum;
    logic signed [PROD_W-1:0] r4, r16, r30;
    logic                     accept;
    logic                     op_last;

    dgf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dgf_ratio_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == ST_DSTART),
        .dt     (dt_reg),
        .tconst (cfg.tconst[axis_reg]),
        .done   (div_done),
        .ratio  (div_ratio)
    );

    dgf_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_LOAD),
        .a     (op_a),
        .b     (op_b),
        .done  (mul_done),
        .prod  (prod)
    );

    assign in_ready  = state_reg == ST_IDLE;
    assign accept    = in_valid & in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Derived coefficients: C = 1 - 2P, Q = 1 - P
    assign c_val  = ONE_Q30 - {p_reg, 1'b0};
    assign c2_val = {c_val, 1'b0};
    assign q_val  = ONE_Q30[30:0] - p_reg;
    assign qs_sum = {q2_reg[31], q2_reg} + {s_reg[31], s_reg};
    assign qs_dif = {q2_reg[31], q2_reg} - {s_reg[31], s_reg};
    assign xx_sum = {x_reg[axis_reg][15], x_reg[axis_reg]}
                  + {xprev_reg[axis_reg][15], xprev_reg[axis_reg]};

    assign r4  = rnd_shr(prod, 4);
    assign r16 = rnd_shr(prod, 16);
    assign r30 = rnd_shr(prod, 30);

    assign op_last = (op_reg == OP_CY1) || (op_reg == OP_A2Y);

    // Select multiplier operands for the current step
    always_comb
    begin
        unique case (op_reg)
            OP_KP:
            begin
                op_a = {17'd0, cfg.gain[axis_reg]};
                op_b = {2'd0, p_reg};
            end
            OP_GX:
            begin
                op_a = g0_reg;
                op_b = {{16{xx_sum[16]}}, xx_sum};
            end
            OP_CY1:
            begin
                op_a = {{16{c_val[31]}}, c_val};
                op_b = {y1_reg[axis_reg][31], y1_reg[axis_reg]};
            end
            OP_QQ:
            begin
                op_a = {17'd0, q_val};
                op_b = {2'd0, q_val};
            end
            OP_PQ:
            begin
                op_a = {17'd0, p_reg};
                op_b = {2'd0, q_val};
            end
            OP_S:
            begin
                op_a = SQRT3_Q30;
                op_b = {pq_reg[31], pq_reg};
            end
            OP_CC:
            begin
                op_a = {{16{c_val[31]}}, c_val};
                op_b = {c_val[31], c_val};
            end
            OP_G0:
            begin
                op_a = {17'd0, cfg.gain[axis_reg]};
                op_b = qs_sum;
            end
            OP_G1:
            begin
                op_a = {17'd0, cfg.gain[axis_reg]};
                op_b = qs_dif;
            end
            OP_G0X:
            begin
                op_a = g0_reg;
                op_b = {{17{x_reg[axis_reg][15]}}, x_reg[axis_reg]};
            end
            OP_G1X:
            begin
                op_a = g1_reg;
                op_b = {{17{xprev_reg[axis_reg][15]}}, xprev_reg[axis_reg]};
            end
            OP_C2Y:
            begin
                op_a = {{15{c2_val[32]}}, c2_val};
                op_b = {y1_reg[axis_reg][31], y1_reg[axis_reg]};
            end
            OP_A2Y:
            begin
                op_a = {{16{a2_reg[31]}}, a2_reg};
                op_b = {y2_reg[axis_reg][31], y2_reg[axis_reg]};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_MUL;
            ST_MUL:    if (mul_done) state_next = ST_POST;
            ST_POST:   state_next = op_last ? ST_FIN : ST_LOAD;
            ST_FIN:    state_next = (axis_reg == 2'd2) ? ST_OUT : ST_DSTART;
            ST_OUT:    if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Control and filter history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg      <= '0;
            op_reg        <= OP_KP;
            prev_time_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                xprev_reg[i] <= '0;
                y1_reg[i]    <= '0;
                y2_reg[i]    <= '0;
            end
        end
        else
        begin
            // Take the transaction, note the time stamp
            if (accept)
            begin
                prev_time_reg <= in_data.time_us;
                axis_reg      <= '0;
            end

            // Pick the program for this axis
            if (state_reg == ST_DIV && div_done)
                op_reg <= (axis_reg == 2'd0) ? OP_KP : OP_QQ;

            if (state_reg == ST_POST && !op_last)
                op_reg <= op_t'(op_reg + 4'd1);

            // Shift the new output into the history, advance the axis
            if (state_reg == ST_FIN)
            begin
                xprev_reg[axis_reg] <= x_reg[axis_reg];
                y2_reg[axis_reg]    <= y1_reg[axis_reg];
                y1_reg[axis_reg]    <= sat_rnd26(acc_reg);
                if (axis_reg != 2'd2)
                    axis_reg <= axis_reg + 2'd1;
            end

            // Output register
            if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dt_reg   <= (in_data.time_us > prev_time_reg) ?
                        in_data.time_us - prev_time_reg : DEFAULT_DT;
            x_reg[0] <= in_data.noise_long;
            x_reg[1] <= in_data.noise_lat;
            x_reg[2] <= in_data.noise_vert;
        end

        if (state_reg == ST_DIV && div_done)
            p_reg <= div_ratio;

        if (state_reg == ST_POST)
        begin
            unique case (op_reg)
                OP_KP:   g0_reg  <= r16[47:0];
                OP_GX:   acc_reg <= prod[ACC_W-1:0];
                OP_CY1:  acc_reg <= acc_reg + r4[ACC_W-1:0];
                OP_QQ:   q2_reg  <= r30[31:0];
                OP_PQ:   pq_reg  <= r30[31:0];
                OP_S:    s_reg   <= r30[31:0];
                OP_CC:   a2_reg  <= r30[31:0];
                OP_G0:   g0_reg  <= r16[47:0];
                OP_G1:   g1_reg  <= r16[47:0];
                OP_G0X:  acc_reg <= prod[ACC_W-1:0];
                OP_G1X:  acc_reg <= acc_reg + prod[ACC_W-1:0];
                OP_C2Y:  acc_reg <= acc_reg + r4[ACC_W-1:0];
                OP_A2Y:  acc_reg <= acc_reg - r4[ACC_W-1:0];
                default: ;
            endcase
        end

        if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
        begin
            out_reg.gust_long <= y1_reg[0];
            out_reg.gust_lat  <= y1_reg[1];
            out_reg.gust_vert <= y1_reg[2];
        end
    end

`ifndef SYNTHESIS
    // A new result only appears after the output step
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    // The ratio never exceeds one half in Q31, i.e. one in Q30
    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (div_ratio <= ONE_Q30[30:0]))
        else $error("step ratio out of range");

    // Multiplier finishes only while the sequencer waits for it
    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL))
        else $error("multiply finished while not awaited");

    // Axis index stays within the three filters
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg != 2'd3)
        else $error("axis index out of range");
`endif

endmodule

// ===== hw/rtl/dgf_cfg.sv =====
module dgf_cfg (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output dgf_pkg::cfg_t cfg
);
    import dgf_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register; drop writes past the map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain   <= '0;
            cfg_reg.tconst <= {3{TCONST_INIT}};
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_GAIN_LONG:   cfg_reg.gain[0]   <= pwdata[30:0];
                REG_GAIN_LAT:    cfg_reg.gain[1]   <= pwdata[30:0];
                REG_GAIN_VERT:   cfg_reg.gain[2]   <= pwdata[30:0];
                REG_TCONST_LONG: cfg_reg.tconst[0] <= pwdata;
                REG_TCONST_LAT:  cfg_reg.tconst[1] <= pwdata;
                REG_TCONST_VERT: cfg_reg.tconst[2] <= pwdata;
                default:         ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_GAIN_LONG:   prdata = {1'b0, cfg_reg.gain[0]};
            REG_GAIN_LAT:    prdata = {1'b0, cfg_reg.gain[1]};
            REG_GAIN_VERT:   prdata = {1'b0, cfg_reg.gain[2]};
            REG_TCONST_LONG: prdata = cfg_reg.tconst[0];
            REG_TCONST_LAT:  prdata = cfg_reg.tconst[1];
            REG_TCONST_VERT: prdata = cfg_reg.tconst[2];
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/dgf_ratio_div.sv =====
module dgf_ratio_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dt,
    input  logic [31:0] tconst,
    output logic        done,
    output logic [30:0] ratio
);
    import dgf_pkg::*;

    logic [48:0] s_reg;
    logic [48:0] r_reg;
    logic [31:0] q_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [31:0] t_eff;
    logic [49:0] r_sh;
    logic        ge;
    logic [49:0] r_sub;
    logic [32:0] q_inc;

    // Zero time constant counts as one
    assign t_eff = (tconst == '0) ? 32'd1 : tconst;

    // First step compares without a shift, the other 31 shift first
    assign r_sh  = (cnt_reg == '0) ? {1'b0, r_reg} : {r_reg, 1'b0};
    assign ge    = r_sh >= {1'b0, s_reg};
    assign r_sub = r_sh - {1'b0, s_reg};

    // Round the 31-fraction-bit quotient to Q30
    assign q_inc = {1'b0, q_reg} + 33'd1;
    assign ratio = q_inc[31:1];
    assign done  = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Restoring division datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg <= {1'b0, dt} + {16'd0, t_eff, 1'b0};
            r_reg <= {1'b0, dt};
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? r_sub[48:0] : r_sh[48:0];
            q_reg <= {q_reg[30:0], ge};
        end
    end

endmodule

// ===== hw/rtl/dgf_serial_mul.sv =====
module dgf_serial_mul (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [47:0]               a,
    input  logic signed [32:0]               b,
    output logic                             done,
    output logic signed [dgf_pkg::PROD_W-1:0] prod
);
    import dgf_pkg::*;

    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] a_sh_reg;
    logic        [32:0]       b_reg;
    logic        [5:0]        cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic signed [PROD_W-1:0] addend;
    logic                     last;

    // The sign bit of b carries negative weight
    assign addend = b_reg[0] ? a_sh_reg : '0;
    assign last   = cnt_reg == 6'd32;
    assign done   = done_reg;
    assign prod   = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift-and-add over the bits of b
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= '0;
            a_sh_reg <= {{(PROD_W-48){a[47]}}, a};
            b_reg    <= b;
        end
        else if (busy_reg)
        begin
            acc_reg  <= last ? acc_reg - addend : acc_reg + addend;
            a_sh_reg <= a_sh_reg <<< 1;
            b_reg    <= {1'b0, b_reg[32:1]};
        end
    end

endmodule
